/* rtl/sg_pkg.sv */
// shared types and constants for the spatial stereo gain pipeline
// no dependencies
package sg_pkg;

  localparam int COORD_W   = 20;
  localparam int DELTA_W   = 21;
  localparam int AXIS_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int SQ_W      = 42;
  localparam int DIST_W    = SQ_W / 2;
  localparam int DOT_W     = 37;
  localparam int MAG_W     = 36;
  localparam int QUO_W     = 16;
  localparam int ATT_W     = 17;
  localparam int WRAD_W    = 30;
  localparam int WT_W      = WRAD_W / 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXIMUM   = 2'd1;

  localparam logic [COORD_W-1:0] REFERENCE_RESET = 20'd4096;
  localparam logic [COORD_W-1:0] MAXIMUM_RESET   = 20'd61440;

  localparam logic [15:0]       ONE_Q14    = 16'd16384;
  localparam logic [ATT_W-1:0]  ATT_ONE    = 17'd65536;
  localparam logic [DIST_W-1:0] PAN_MIN    = 21'd2;

  typedef struct packed {
    logic spatial;
    logic silent;
    logic near;
    logic close;
    logic ovf;
  } flags_t;

  typedef struct packed {
    flags_t              flags;
    logic [GAIN_W-1:0]   gain;
  } side_t;

endpackage

/* rtl/sg_front.sv */
// front stages: position deltas, squared distance and dot product with ear axis
// depends on sg_pkg
module sg_front import sg_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [COORD_W-1:0] source_x_i,
  input  logic signed [COORD_W-1:0] source_y_i,
  input  logic signed [COORD_W-1:0] source_z_i,
  input  logic signed [COORD_W-1:0] listener_x_i,
  input  logic signed [COORD_W-1:0] listener_y_i,
  input  logic signed [COORD_W-1:0] listener_z_i,
  input  logic signed [AXIS_W-1:0]  ear_axis_x_i,
  input  logic signed [AXIS_W-1:0]  ear_axis_y_i,
  input  logic signed [AXIS_W-1:0]  ear_axis_z_i,
  input  logic [GAIN_W-1:0]         base_gain_i,
  input  logic                      is_spatial_i,
  output logic                      valid_o,
  output logic [SQ_W-1:0]           sq_o,
  output logic signed [DOT_W-1:0]   dot_o,
  output logic [GAIN_W-1:0]         gain_o,
  output logic                      spatial_o
);

  logic [1:0]                vld_q;
  logic signed [DELTA_W-1:0] d_q [3];
  logic signed [DELTA_W-1:0] d_d [3];
  logic signed [AXIS_W-1:0]  e_q [3];
  logic [GAIN_W-1:0]         gain1_q, gain2_q;
  logic                      sp1_q, sp2_q;
  logic [SQ_W-1:0]           sq_q, sq_d;
  logic signed [DOT_W-1:0]   dot_q, dot_d;
  logic signed [SQ_W-1:0]    p [3];
  logic signed [DOT_W-1:0]   m [3];

  // deltas per axis
  assign d_d[0] = DELTA_W'(source_x_i) - DELTA_W'(listener_x_i);
  assign d_d[1] = DELTA_W'(source_y_i) - DELTA_W'(listener_y_i);
  assign d_d[2] = DELTA_W'(source_z_i) - DELTA_W'(listener_z_i);

  // squares and projections
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p[k] = d_q[k] * d_q[k];
      m[k] = DOT_W'(d_q[k]) * DOT_W'(e_q[k]);
    end
    sq_d  = SQ_W'(unsigned'(p[0])) + SQ_W'(unsigned'(p[1])) + SQ_W'(unsigned'(p[2]));
    dot_d = m[0] + m[1] + m[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    e_q[0]  <= ear_axis_x_i;
    e_q[1]  <= ear_axis_y_i;
    e_q[2]  <= ear_axis_z_i;
    gain1_q <= base_gain_i;
    sp1_q   <= is_spatial_i;
    sq_q    <= sq_d;
    dot_q   <= dot_d;
    gain2_q <= gain1_q;
    sp2_q   <= sp1_q;
  end

  assign valid_o   = vld_q[1];
  assign sq_o      = sq_q;
  assign dot_o     = dot_q;
  assign gain_o    = gain2_q;
  assign spatial_o = sp2_q;

endmodule

/* rtl/sg_sqrt.sv */
// pipelined integer square root, one root bit per stage
// no package dependencies
module sg_sqrt #(
  parameter int IN_W = 42,
  parameter int SB_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SB_W-1:0]   side_i,
  output logic              valid_o,
  output logic [IN_W/2-1:0] root_o,
  output logic [SB_W-1:0]   side_o
);

  localparam int RW = IN_W / 2;

  logic [RW-1:0]   vld_q;
  logic [RW+1:0]   rem_q  [RW];
  logic [RW+1:0]   rem_d  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [RW-1:0]   root_d [RW];
  logic [IN_W-1:0] rad_q  [RW];
  logic [IN_W-1:0] rad_d  [RW];
  logic [SB_W-1:0] sb_q   [RW];

  // one restoring step per stage
  always_comb begin
    logic [RW+1:0]   rem_in;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic [RW-1:0]   root_in;
    logic [IN_W-1:0] rad_in;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = rad_i;
      end else begin
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
        rad_in  = rad_q[k-1];
      end
      rem_sh = {rem_in[RW-1:0], rad_in[IN_W-1 -: 2]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d[k]  = rem_sh - trial;
        root_d[k] = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_d[k]  = rem_sh;
        root_d[k] = {root_in[RW-2:0], 1'b0};
      end
      rad_d[k] = rad_in << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[RW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= rad_d;
    sb_q[0] <= side_i;
    for (int k = 1; k < RW; k++) begin
      sb_q[k] <= sb_q[k-1];
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = sb_q[RW-1];

endmodule

/* rtl/sg_div.sv */
// pipelined restoring divider, one quotient bit per stage
// quotient is valid when the numerator top bits are below the divisor
module sg_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 21,
  parameter int Q_W   = 16,
  parameter int SB_W  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  side_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output logic [SB_W-1:0]  side_o
);

  logic [Q_W-1:0]   vld_q;
  logic [DEN_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] rem_d [Q_W];
  logic [Q_W-1:0]   lo_q  [Q_W];
  logic [Q_W-1:0]   lo_d  [Q_W];
  logic [Q_W-1:0]   q_q   [Q_W];
  logic [Q_W-1:0]   q_d   [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [SB_W-1:0]  sb_q  [Q_W];

  // one subtract and compare per stage
  always_comb begin
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W:0]   rem_sh;
    logic [Q_W-1:0]   lo_in;
    logic [Q_W-1:0]   q_in;
    logic [DEN_W-1:0] den_in;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        rem_in = DEN_W'(num_i[NUM_W-1:Q_W]);
        lo_in  = num_i[Q_W-1:0];
        q_in   = '0;
        den_in = den_i;
      end else begin
        rem_in = rem_q[k-1];
        lo_in  = lo_q[k-1];
        q_in   = q_q[k-1];
        den_in = den_q[k-1];
      end
      rem_sh = {rem_in, lo_in[Q_W-1]};
      if (rem_sh >= {1'b0, den_in}) begin
        rem_d[k] = DEN_W'(rem_sh - {1'b0, den_in});
        q_d[k]   = {q_in[Q_W-2:0], 1'b1};
      end else begin
        rem_d[k] = rem_sh[DEN_W-1:0];
        q_d[k]   = {q_in[Q_W-2:0], 1'b0};
      end
      lo_d[k] = lo_in << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Q_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    lo_q     <= lo_d;
    q_q      <= q_d;
    den_q[0] <= den_i;
    sb_q[0]  <= side_i;
    for (int k = 1; k < Q_W; k++) begin
      den_q[k] <= den_q[k-1];
      sb_q[k]  <= sb_q[k-1];
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = q_q[Q_W-1];
  assign side_o  = sb_q[Q_W-1];

endmodule

/* rtl/sg_prep.sv */
// range checks on the distance and magnitude of the projection
// depends on sg_pkg
module sg_prep import sg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [DIST_W-1:0]       dist_i,
  input  logic signed [DOT_W-1:0] dot_i,
  input  logic [GAIN_W-1:0]       gain_i,
  input  logic                    spatial_i,
  input  logic [COORD_W-1:0]      reference_range_i,
  input  logic [COORD_W-1:0]      maximum_range_i,
  output logic                    valid_o,
  output logic [DIST_W-1:0]       dist_o,
  output logic [MAG_W-1:0]        mag_o,
  output logic                    neg_o,
  output side_t                   side_o
);

  logic              vld_q;
  logic [DIST_W-1:0] dist_q;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic              neg_q, neg_d;
  side_t             side_q, side_d;
  logic [DOT_W-1:0]  abs_dot;

  // magnitude of the projection and distance tests
  always_comb begin
    neg_d   = dot_i[DOT_W-1];
    abs_dot = neg_d ? DOT_W'(-dot_i) : DOT_W'(dot_i);
    mag_d   = abs_dot[MAG_W-1:0];
    side_d.gain          = gain_i;
    side_d.flags.spatial = spatial_i;
    side_d.flags.silent  = dist_i >= {1'b0, maximum_range_i};
    side_d.flags.near    = dist_i <= {1'b0, reference_range_i};
    side_d.flags.close   = dist_i < PAN_MIN;
    side_d.flags.ovf     = {1'b0, mag_d[MAG_W-1:QUO_W]} >= dist_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_i;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    side_q <= side_d;
  end

  assign valid_o = vld_q;
  assign dist_o  = dist_q;
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;
  assign side_o  = side_q;

endmodule

/* rtl/sg_pan.sv */
// pan clamp, ear weight radicands and attenuation select
// depends on sg_pkg
module sg_pan import sg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [QUO_W-1:0]  att_quo_i,
  input  logic [QUO_W-1:0]  pan_quo_i,
  input  logic              neg_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [WRAD_W-1:0] rad_left_o,
  output logic [WRAD_W-1:0] rad_right_o,
  output logic [ATT_W-1:0]  att_o,
  output side_t             side_o
);

  logic              vld_q;
  logic [WRAD_W-1:0] radl_q, radl_d, radr_q, radr_d;
  logic [ATT_W-1:0]  att_q, att_d;
  side_t             side_q;
  logic [15:0]       qc;
  logic [15:0]       lo_term, hi_term;

  // clamp the cosine and build both radicands
  always_comb begin
    if (side_i.flags.close) begin
      qc = '0;
    end else if (side_i.flags.ovf || pan_quo_i > ONE_Q14) begin
      qc = ONE_Q14;
    end else begin
      qc = pan_quo_i;
    end
    lo_term = ONE_Q14 - qc;
    hi_term = ONE_Q14 + qc;
    if (neg_i) begin
      radl_d = WRAD_W'({hi_term, 13'b0});
      radr_d = WRAD_W'({lo_term, 13'b0});
    end else begin
      radl_d = WRAD_W'({lo_term, 13'b0});
      radr_d = WRAD_W'({hi_term, 13'b0});
    end
    att_d = side_i.flags.near ? ATT_ONE : {1'b0, att_quo_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    radl_q <= radl_d;
    radr_q <= radr_d;
    att_q  <= att_d;
    side_q <= side_i;
  end

  assign valid_o     = vld_q;
  assign rad_left_o  = radl_q;
  assign rad_right_o = radr_q;
  assign att_o       = att_q;
  assign side_o      = side_q;

endmodule

/* rtl/sg_back.sv */
// final gain products and result select, registered result strobe
// depends on sg_pkg
module sg_back import sg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [WT_W-1:0]   weight_left_i,
  input  logic [WT_W-1:0]   weight_right_i,
  input  logic [ATT_W-1:0]  att_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [GAIN_W-1:0] left_gain_o,
  output logic [GAIN_W-1:0] right_gain_o
);

  localparam int GA_W   = GAIN_W + ATT_W;
  localparam int PROD_W = GA_W + WT_W;

  logic [1:0]        vld_q;
  logic [GA_W-1:0]   ga_q;
  logic [WT_W-1:0]   wl_q, wr_q;
  side_t             side_q;
  logic [PROD_W-1:0] pl, pr;
  logic [GAIN_W-1:0] left_q, left_d, right_q, right_d;

  // weighted gains, scaled back to q2.14
  always_comb begin
    pl = PROD_W'(ga_q) * PROD_W'(wl_q);
    pr = PROD_W'(ga_q) * PROD_W'(wr_q);
    if (!side_q.flags.spatial) begin
      left_d  = side_q.gain;
      right_d = side_q.gain;
    end else if (side_q.flags.silent) begin
      left_d  = '0;
      right_d = '0;
    end else begin
      left_d  = pl[30 +: GAIN_W];
      right_d = pr[30 +: GAIN_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ga_q    <= GA_W'(side_i.gain) * GA_W'(att_i);
    wl_q    <= weight_left_i;
    wr_q    <= weight_right_i;
    side_q  <= side_i;
    left_q  <= left_d;
    right_q <= right_d;
  end

  assign valid_o      = vld_q[1];
  assign left_gain_o  = left_q;
  assign right_gain_o = right_q;

endmodule

/* rtl/spatial_stereo_gain.sv */
// top level of the stereo gain pipeline and its two range registers
// depends on sg_pkg, sg_front, sg_sqrt, sg_div, sg_prep, sg_pan, sg_back
//
// Takes one item per clock on start_i (busy_o stays low) and returns left and right
// ear gains, marked by a one-cycle valid_o strobe; the receiver cannot stall. The pipeline
// is built from one-bit-per-stage units: 21 square-root steps for the distance, 16 divider
// steps with the attenuation and pan quotients on two dividers side by side, 15
// square-root steps for the ear weights, plus six register stages around them. Range
// registers are written through the cfg port, index 0 the reference range and index 1
// the maximum range; other indexes are ignored.
module spatial_stereo_gain import sg_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [COORD_W-1:0]        cfg_data_i,
  input  logic signed [COORD_W-1:0] source_x_i,
  input  logic signed [COORD_W-1:0] source_y_i,
  input  logic signed [COORD_W-1:0] source_z_i,
  input  logic signed [COORD_W-1:0] listener_x_i,
  input  logic signed [COORD_W-1:0] listener_y_i,
  input  logic signed [COORD_W-1:0] listener_z_i,
  input  logic signed [AXIS_W-1:0]  ear_axis_x_i,
  input  logic signed [AXIS_W-1:0]  ear_axis_y_i,
  input  logic signed [AXIS_W-1:0]  ear_axis_z_i,
  input  logic [GAIN_W-1:0]         base_gain_i,
  input  logic                      is_spatial_i,
  output logic                      valid_o,
  output logic [GAIN_W-1:0]         left_gain_o,
  output logic [GAIN_W-1:0]         right_gain_o
);

  localparam int LATENCY = 2 + DIST_W + 1 + QUO_W + 1 + WT_W + 2;

  logic [COORD_W-1:0] reference_range_q, maximum_range_q;
  logic               accept;

  logic                    f_vld;
  logic [SQ_W-1:0]         f_sq;
  logic signed [DOT_W-1:0] f_dot;
  logic [GAIN_W-1:0]       f_gain;
  logic                    f_sp;

  logic                    s_vld;
  logic [DIST_W-1:0]       s_dist;
  logic [DOT_W+GAIN_W:0]   s_side;

  logic                    p_vld;
  logic [DIST_W-1:0]       p_dist;
  logic [MAG_W-1:0]        p_mag;
  logic                    p_neg;
  side_t                   p_side;

  logic                    da_vld, dp_vld;
  logic [QUO_W-1:0]        da_quo, dp_quo;
  side_t                   da_side;
  logic                    dp_neg;

  logic                    n_vld;
  logic [WRAD_W-1:0]       n_radl, n_radr;
  logic [ATT_W-1:0]        n_att;
  side_t                   n_side;

  logic                    wl_vld, wr_vld;
  logic [WT_W-1:0]         wl, wr;
  logic [ATT_W-1:0]        w_att;
  side_t                   w_side;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // range registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reference_range_q <= REFERENCE_RESET;
      maximum_range_q   <= MAXIMUM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_REFERENCE) begin
        reference_range_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_MAXIMUM) begin
        maximum_range_q <= cfg_data_i;
      end
    end
  end

  sg_front u_front (
    .clk_i, .rst_ni,
    .valid_i   (accept),
    .source_x_i, .source_y_i, .source_z_i,
    .listener_x_i, .listener_y_i, .listener_z_i,
    .ear_axis_x_i, .ear_axis_y_i, .ear_axis_z_i,
    .base_gain_i, .is_spatial_i,
    .valid_o   (f_vld),
    .sq_o      (f_sq),
    .dot_o     (f_dot),
    .gain_o    (f_gain),
    .spatial_o (f_sp)
  );

  // distance
  sg_sqrt #(.IN_W(SQ_W), .SB_W(DOT_W + GAIN_W + 1)) u_dist (
    .clk_i, .rst_ni,
    .valid_i (f_vld),
    .rad_i   (f_sq),
    .side_i  ({f_dot, f_gain, f_sp}),
    .valid_o (s_vld),
    .root_o  (s_dist),
    .side_o  (s_side)
  );

  sg_prep u_prep (
    .clk_i, .rst_ni,
    .valid_i           (s_vld),
    .dist_i            (s_dist),
    .dot_i             (s_side[DOT_W+GAIN_W:GAIN_W+1]),
    .gain_i            (s_side[GAIN_W:1]),
    .spatial_i         (s_side[0]),
    .reference_range_i (reference_range_q),
    .maximum_range_i   (maximum_range_q),
    .valid_o           (p_vld),
    .dist_o            (p_dist),
    .mag_o             (p_mag),
    .neg_o             (p_neg),
    .side_o            (p_side)
  );

  // attenuation quotient
  sg_div #(.NUM_W(COORD_W + QUO_W), .DEN_W(DIST_W), .Q_W(QUO_W),
           .SB_W($bits(side_t))) u_att_div (
    .clk_i, .rst_ni,
    .valid_i (p_vld),
    .num_i   ({reference_range_q, {QUO_W{1'b0}}}),
    .den_i   (p_dist),
    .side_i  (p_side),
    .valid_o (da_vld),
    .quo_o   (da_quo),
    .side_o  (da_side)
  );

  // cosine quotient
  sg_div #(.NUM_W(MAG_W), .DEN_W(DIST_W), .Q_W(QUO_W), .SB_W(1)) u_pan_div (
    .clk_i, .rst_ni,
    .valid_i (p_vld),
    .num_i   (p_mag),
    .den_i   (p_dist),
    .side_i  (p_neg),
    .valid_o (dp_vld),
    .quo_o   (dp_quo),
    .side_o  (dp_neg)
  );

  sg_pan u_pan (
    .clk_i, .rst_ni,
    .valid_i     (da_vld),
    .att_quo_i   (da_quo),
    .pan_quo_i   (dp_quo),
    .neg_i       (dp_neg),
    .side_i      (da_side),
    .valid_o     (n_vld),
    .rad_left_o  (n_radl),
    .rad_right_o (n_radr),
    .att_o       (n_att),
    .side_o      (n_side)
  );

  // ear weights
  sg_sqrt #(.IN_W(WRAD_W), .SB_W(ATT_W)) u_wl (
    .clk_i, .rst_ni,
    .valid_i (n_vld),
    .rad_i   (n_radl),
    .side_i  (n_att),
    .valid_o (wl_vld),
    .root_o  (wl),
    .side_o  (w_att)
  );

  sg_sqrt #(.IN_W(WRAD_W), .SB_W($bits(side_t))) u_wr (
    .clk_i, .rst_ni,
    .valid_i (n_vld),
    .rad_i   (n_radr),
    .side_i  (n_side),
    .valid_o (wr_vld),
    .root_o  (wr),
    .side_o  (w_side)
  );

  sg_back u_back (
    .clk_i, .rst_ni,
    .valid_i        (wl_vld),
    .weight_left_i  (wl),
    .weight_right_i (wr),
    .att_i          (w_att),
    .side_i         (w_side),
    .valid_o,
    .left_gain_o,
    .right_gain_o
  );

  // checks
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wl_vld == wr_vld) && (da_vld == dp_vld))
    else $error("parallel lanes out of step");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LATENCY))
    else $error("result without an accepted item");

  a_flat_passes_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !$past(is_spatial_i, LATENCY) |->
      (left_gain_o == $past(base_gain_i, LATENCY)) && (right_gain_o == left_gain_o))
    else $error("flat item gain mismatch");

endmodule
